// ----- rtl/rsr_pkg.sv -----
package rsr_pkg;

	typedef struct packed {
		logic        req_type;
		logic [10:0] set_index;
		logic [3:0]  way_index;
		logic [47:0] pc;
		logic [47:0] paddr;
		logic        hit;
	} req_t;

	typedef struct packed {
		logic [3:0] victim_way;
		logic       streaming_seen;
	} rsp_t;

	// Classified command handed from the front to the back. The set and
	// signature fields are sized for the largest legal configuration.
	typedef struct packed {
		logic        is_update;
		logic [15:0] set;
		logic [3:0]  way;
		logic [15:0] sig;
		logic [31:0] addr_low;
		logic        hit;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	localparam logic       REQ_QUERY   = 1'b0;
	localparam logic       REQ_UPDATE  = 1'b1;
	localparam logic [1:0] RRV_MAX     = 2'd3;
	localparam logic [1:0] RRV_NEAR    = 2'd0;
	localparam logic [1:0] RRV_INTER   = 2'd1;
	localparam logic [1:0] CNT_MAX     = 2'd3;
	localparam logic [1:0] CNT_ZERO    = 2'd0;
	localparam logic [1:0] SIG_RESET   = 2'd1;
	localparam logic [1:0] SIG_HOT     = 2'd2;
	localparam int         QUEUE_DEPTH = 2;

endpackage

// ----- rtl/rsr_front.sv -----
module rsr_front #(
	parameter int NUM_SETS       = 2048,
	parameter int SIGNATURE_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rsr_pkg::req_t req,
	input  logic          clearing,
	input  logic          q_full,
	output logic          busy,
	output logic          push,
	output rsr_pkg::cmd_t push_cmd
);
	import rsr_pkg::*;

	// Set reduction by multiplying with a rounded-up reciprocal; exact for 11-bit sets.
	localparam int          SH      = 28;
	localparam longint      RECIP_L = ((64'd1 << SH) + NUM_SETS - 1) / NUM_SETS;
	localparam logic [28:0] RECIP   = 29'(RECIP_L);
	localparam logic [27:0] NSETS   = 28'(NUM_SETS);

	logic        v_s1, v_s2;
	req_t        req_s1, req_s2;
	logic [10:0] quot_s2;
	logic [39:0] prod;
	logic [27:0] rem;
	logic [SIGNATURE_BITS-1:0] sig;
	logic        s2_free, mov1, s1_free;

	assign push    = v_s2 && !q_full;
	assign s2_free = !v_s2 || push;
	assign mov1    = v_s1 && s2_free;
	assign s1_free = !v_s1 || mov1;
	assign busy    = clearing || !s1_free;

	assign prod = 40'(req_s1.set_index) * 40'(RECIP);
	assign rem  = 28'(req_s2.set_index) - 28'(quot_s2) * NSETS;
	assign sig  = SIGNATURE_BITS'(req_s2.pc ^ (req_s2.pc >> 2));

	always_comb begin
		push_cmd.is_update = (req_s2.req_type == REQ_UPDATE);
		push_cmd.set       = 16'(rem);
		push_cmd.way       = req_s2.way_index;
		push_cmd.sig       = 16'(sig);
		push_cmd.addr_low  = req_s2.paddr[31:0];
		push_cmd.hit       = req_s2.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_free) v_s1 <= start && !busy;
			if (s2_free) v_s2 <= mov1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) req_s1 <= req;
		if (mov1) begin
			req_s2  <= req_s1;
			quot_s2 <= prod[SH+10:SH];
		end
	end

endmodule

// ----- rtl/rsr_queue.sv -----
module rsr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rsr_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output rsr_pkg::cmd_t      head,
	output rsr_pkg::q_status_t status
);
	import rsr_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == (PW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ----- rtl/rsr_back.sv -----
module rsr_back #(
	parameter int NUM_SETS       = 2048,
	parameter int NUM_WAYS       = 16,
	parameter int SIGNATURE_BITS = 12,
	parameter int DELTA_DEPTH    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rsr_pkg::cmd_t      head,
	input  rsr_pkg::q_status_t q_status,
	output logic               pop,
	output logic               clearing,
	output logic               done,
	output rsr_pkg::rsp_t      result
);
	import rsr_pkg::*;

	localparam int SET_W   = $clog2(NUM_SETS > 1 ? NUM_SETS : 2);
	localparam int WAY_W   = $clog2(NUM_WAYS);
	localparam int SLOT_W  = $clog2(DELTA_DEPTH);
	localparam int SIG_N   = 1 << SIGNATURE_BITS;
	localparam int CLR_N   = NUM_SETS > SIG_N ? NUM_SETS : SIG_N;
	localparam int CLR_W   = $clog2(CLR_N + 1);

	typedef logic [NUM_WAYS-1:0][1:0]     row2_t;
	typedef logic [DELTA_DEPTH-1:0][31:0] ring_t;

	row2_t               rrv_mem  [NUM_SETS];
	row2_t               dead_mem [NUM_SETS];
	logic [31:0]         last_mem [NUM_SETS];
	ring_t               ring_mem [NUM_SETS];
	logic [SLOT_W-1:0]   slot_mem [NUM_SETS];
	logic [1:0]          sig_mem  [SIG_N];

	back_state_t         state_q, state_d;
	logic [CLR_W-1:0]    clr_q;
	cmd_t                cmd_q;
	row2_t               rrv_rd_q, dead_rd_q;
	logic [31:0]         last_rd_q;
	ring_t               ring_rd_q;
	logic [SLOT_W-1:0]   slot_rd_q;
	logic [1:0]          sig_rd_q;
	logic                exec_en, clr_last;

	logic [SET_W-1:0]          rd_set, ex_set, clr_set;
	logic [SIGNATURE_BITS-1:0] rd_sig, ex_sig, clr_sig;

	row2_t             rrv_new, dead_new, age1, age2;
	ring_t             ring_new;
	logic [SLOT_W-1:0] slot_new;
	logic [1:0]        sig_new;
	logic [3:0]        victim;
	logic              found1, found2, stream, way_ok;
	logic [WAY_W-1:0]  w1, w2, wi;

	assign rd_set   = head.set[SET_W-1:0];
	assign rd_sig   = head.sig[SIGNATURE_BITS-1:0];
	assign ex_set   = cmd_q.set[SET_W-1:0];
	assign ex_sig   = cmd_q.sig[SIGNATURE_BITS-1:0];
	assign clr_set  = SET_W'(clr_q);
	assign clr_sig  = SIGNATURE_BITS'(clr_q);
	assign clr_last = (clr_q == CLR_W'(CLR_N - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_last) state_d = BK_IDLE;
			BK_IDLE:  if (!q_status.empty) state_d = BK_EXEC;
			BK_EXEC:  state_d = BK_IDLE;
			default:  state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		exec_en  = 1'b0;
		clearing = 1'b0;
		unique case (state_q)
			BK_CLEAR: clearing = 1'b1;
			BK_IDLE:  pop = !q_status.empty;
			BK_EXEC:  exec_en = 1'b1;
			default:  clearing = 1'b1;
		endcase
	end

	always_comb begin
		found1 = 1'b0;
		found2 = 1'b0;
		w1     = '0;
		w2     = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			age1[w] = (rrv_rd_q[w] < RRV_MAX) ? rrv_rd_q[w] + 2'd1 : rrv_rd_q[w];
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			age2[w] = (age1[w] < RRV_MAX) ? age1[w] + 2'd1 : age1[w];
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rrv_rd_q[w] == RRV_MAX && dead_rd_q[w] == CNT_ZERO) begin
				found1 = 1'b1;
				w1     = WAY_W'(w);
			end
			if (age1[w] == RRV_MAX) begin
				found2 = 1'b1;
				w2     = WAY_W'(w);
			end
		end

		ring_new = ring_rd_q;
		ring_new[slot_rd_q] = cmd_q.addr_low - last_rd_q;
		slot_new = (slot_rd_q == SLOT_W'(DELTA_DEPTH - 1)) ? '0 : slot_rd_q + 1'b1;
		stream   = (ring_new[0] != 32'd0);
		for (int i = 1; i < DELTA_DEPTH; i++) begin
			if (ring_new[i] != ring_new[0]) stream = 1'b0;
		end

		way_ok   = (32'(cmd_q.way) < 32'(NUM_WAYS));
		wi       = WAY_W'(cmd_q.way);
		rrv_new  = rrv_rd_q;
		dead_new = dead_rd_q;
		sig_new  = sig_rd_q;
		victim   = 4'd0;

		if (!cmd_q.is_update) begin
			priority if (found1) begin
				victim = 4'(w1);
			end else if (found2) begin
				rrv_new = age1;
				victim  = 4'(w2);
			end else begin
				rrv_new = age2;
			end
		end else if (cmd_q.hit) begin
			if (way_ok) begin
				rrv_new[wi] = RRV_NEAR;
				if (dead_rd_q[wi] < CNT_MAX) dead_new[wi] = dead_rd_q[wi] + 2'd1;
			end
			if (sig_rd_q < CNT_MAX) sig_new = sig_rd_q + 2'd1;
		end else begin
			if (way_ok) begin
				priority if (stream) rrv_new[wi] = RRV_MAX;
				else if (sig_rd_q >= SIG_HOT) rrv_new[wi] = RRV_NEAR;
				else if (dead_rd_q[wi] == CNT_ZERO) rrv_new[wi] = RRV_MAX;
				else rrv_new[wi] = RRV_INTER;
				dead_new[wi] = CNT_ZERO;
			end
			if (sig_rd_q > CNT_ZERO) sig_new = sig_rd_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			done <= exec_en;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q     <= head;
			rrv_rd_q  <= rrv_mem[rd_set];
			dead_rd_q <= dead_mem[rd_set];
			last_rd_q <= last_mem[rd_set];
			ring_rd_q <= ring_mem[rd_set];
			slot_rd_q <= slot_mem[rd_set];
			sig_rd_q  <= sig_mem[rd_sig];
		end
		if (exec_en) begin
			result.victim_way     <= victim;
			result.streaming_seen <= cmd_q.is_update && stream;
			rrv_mem[ex_set]  <= rrv_new;
			dead_mem[ex_set] <= dead_new;
			if (cmd_q.is_update) begin
				last_mem[ex_set] <= cmd_q.addr_low;
				ring_mem[ex_set] <= ring_new;
				slot_mem[ex_set] <= slot_new;
				sig_mem[ex_sig]  <= sig_new;
			end
		end
		if (clearing) begin
			if (32'(clr_q) < 32'(NUM_SETS)) begin
				rrv_mem[clr_set]  <= {NUM_WAYS{RRV_MAX}};
				dead_mem[clr_set] <= '0;
				last_mem[clr_set] <= '0;
				ring_mem[clr_set] <= '0;
				slot_mem[clr_set] <= '0;
			end
			if (32'(clr_q) < 32'(SIG_N)) sig_mem[clr_sig] <= SIG_RESET;
		end
	end

	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == BK_EXEC))
		else $error("result strobe without an executed command");

	a_no_pop_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop && !exec_en)
		else $error("command taken during the clearing pass");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC) |=> (state_q == BK_IDLE))
		else $error("execute state held longer than one cycle");

endmodule

// ----- rtl/rrip_signature_stream_replacement_top.sv -----
// Flow: a request taken by the front end passes its stages and the queue; the back end then
// reads the set, stride and signature memories, and in its execute state does the
// read-modify-write and registers the result. It pops one command only after the last is done.
// Reset: the front end and queue empty at once; the back end then clears its memories, one set
// and one signature entry per cycle, over max(NUM_SETS, 2^SIGNATURE_BITS) entries, holding busy.
// Results cannot be stalled: each is shown for one cycle with done high.
module rrip_signature_stream_replacement_top #(
	parameter int NUM_SETS       = 2048,
	parameter int NUM_WAYS       = 16,
	parameter int SIGNATURE_BITS = 12,
	parameter int DELTA_DEPTH    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rsr_pkg::req_t req,
	output logic          done,
	output rsr_pkg::rsp_t result
);
	import rsr_pkg::*;

	// The front end reduces the set and hashes the PC, then hands a command to a
	// two-entry queue so that it can take the next transfer while the back end works.
	logic      push, pop, clearing;
	cmd_t      push_cmd, head;
	q_status_t q_status;

	rsr_front #(
		.NUM_SETS       (NUM_SETS),
		.SIGNATURE_BITS (SIGNATURE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.clearing (clearing),
		.q_full   (q_status.full),
		.busy     (busy),
		.push     (push),
		.push_cmd (push_cmd)
	);

	rsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// The back end owns all replacement state and executes one command at a time,
	// so a read always sees the writes of the command before it.
	rsr_back #(
		.NUM_SETS       (NUM_SETS),
		.NUM_WAYS       (NUM_WAYS),
		.SIGNATURE_BITS (SIGNATURE_BITS),
		.DELTA_DEPTH    (DELTA_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

// ----- dv/tb_rrip_signature_stream_replacement_top.sv -----
`timescale 1ns / 1ps

module tb_rrip_signature_stream_replacement_top;
	import rsr_pkg::*;

	localparam int SETS      = 2048;
	localparam int WAYS      = 16;
	localparam int SIG_N     = 4096;
	localparam int RING      = 4;
	localparam int CYCLE_CAP = 400000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  result;

	rrip_signature_stream_replacement_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	// The clock runs with a 20 ns period, high for the first half.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Shadow copy of the replacement state, kept in step with the block.
	logic [1:0]  rrv_mem [SETS*WAYS];
	logic [1:0]  dead_mem [SETS*WAYS];
	logic [1:0]  sig_mem [SIG_N];
	logic [31:0] prev_addr_low [SETS];
	logic [31:0] ring_mem [SETS*RING];
	logic [1:0]  ring_pos [SETS];

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   mismatches;
	int   cycles;
	bit   took;
	bit   drain_hold;
	bit   no_idle;

	function automatic void clear_shadow();
		for (int i = 0; i < SETS*WAYS; i++) begin
			rrv_mem[i]  = RRV_MAX;
			dead_mem[i] = CNT_ZERO;
		end
		for (int i = 0; i < SIG_N; i++)
			sig_mem[i] = SIG_RESET;
		for (int i = 0; i < SETS; i++) begin
			prev_addr_low[i] = '0;
			ring_pos[i]      = '0;
		end
		for (int i = 0; i < SETS*RING; i++)
			ring_mem[i] = '0;
	endfunction

	function automatic void age_ways(int base);
		for (int w = 0; w < WAYS; w++)
			if (rrv_mem[base+w] != RRV_MAX)
				rrv_mem[base+w] = rrv_mem[base+w] + 2'd1;
	endfunction

	// Computes the result for one request and applies its state change.
	function automatic rsp_t replace_step(req_t r);
		rsp_t        o;
		int          set;
		int          base;
		int          line;
		int          sig;
		int          rb;
		logic [47:0] hsh;
		logic [31:0] now;
		logic [31:0] first;
		bit          stream;
		bit          found;
		o     = '0;
		set   = int'(r.set_index);
		base  = set * WAYS;
		found = 1'b0;
		if (r.req_type == REQ_QUERY) begin
			for (int w = 0; w < WAYS && !found; w++)
				if (rrv_mem[base+w] == RRV_MAX && dead_mem[base+w] == CNT_ZERO) begin
					o.victim_way = 4'(w);
					found = 1'b1;
				end
			if (!found) begin
				age_ways(base);
				for (int w = 0; w < WAYS && !found; w++)
					if (rrv_mem[base+w] == RRV_MAX) begin
						o.victim_way = 4'(w);
						found = 1'b1;
					end
			end
			if (!found) begin
				age_ways(base);
				o.victim_way = '0;
			end
			return o;
		end
		hsh = r.pc ^ (r.pc >> 2);
		sig = int'(hsh[11:0]);
		now = r.paddr[31:0];
		rb  = set * RING;
		ring_mem[rb + ring_pos[set]] = now - prev_addr_low[set];
		ring_pos[set]      = ring_pos[set] + 2'd1;
		prev_addr_low[set] = now;
		first  = ring_mem[rb];
		stream = first != 0;
		for (int i = 1; i < RING; i++)
			if (ring_mem[rb+i] != first)
				stream = 1'b0;
		line = base + int'(r.way_index);
		if (r.hit) begin
			rrv_mem[line] = RRV_NEAR;
			if (dead_mem[line] != CNT_MAX)
				dead_mem[line] = dead_mem[line] + 2'd1;
			if (sig_mem[sig] != CNT_MAX)
				sig_mem[sig] = sig_mem[sig] + 2'd1;
		end else begin
			if (stream)
				rrv_mem[line] = RRV_MAX;
			else if (sig_mem[sig] >= SIG_HOT)
				rrv_mem[line] = RRV_NEAR;
			else if (dead_mem[line] == CNT_ZERO)
				rrv_mem[line] = RRV_MAX;
			else
				rrv_mem[line] = RRV_INTER;
			dead_mem[line] = CNT_ZERO;
			if (sig_mem[sig] != 2'd0)
				sig_mem[sig] = sig_mem[sig] - 2'd1;
		end
		o.streaming_seen = stream;
		return o;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		r.req_type  = 1'($urandom_range(0, 1));
		r.set_index = 11'($urandom_range(0, 2047));
		r.way_index = 4'($urandom_range(0, 15));
		r.pc        = 48'({$urandom(), $urandom()});
		r.paddr     = 48'({$urandom(), $urandom()});
		r.hit       = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic req_t make_req(bit kind, int set, int way, logic [47:0] pc,
			logic [47:0] addr, bit hit);
		req_t r;
		r.req_type  = kind;
		r.set_index = 11'(set);
		r.way_index = 4'(way);
		r.pc        = pc;
		r.paddr     = addr;
		r.hit       = hit;
		return r;
	endfunction

	// The transfer is decided at the rising edge, so it is sampled there.
	always @(posedge clk) begin
		took <= arst_n && start && !busy;
	end

	// Driver: offers the head of the pending queue and pops it on a transfer.
	// The next item is placed right after the transfer edge, so start stays
	// high across back-to-back items without being lowered in between.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// Held until the block takes it.
		end else begin
			if (took) begin
				expected_rsps.push_back(replace_step(req));
				void'(pending_reqs.pop_front());
			end
			if (pending_reqs.size() != 0 && !drain_hold &&
					(no_idle || $urandom_range(0, 99) >= 34)) begin
				req   <= pending_reqs[0];
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done strobe is matched against the oldest prediction.
	// A transfer is booked at the falling edge after the accepting rising
	// edge, before its result can come out of the front end, queue and back end.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result victim=%0d stream=%0b",
						result.victim_way, result.streaming_seen);
			end else begin
				want = expected_rsps.pop_front();
				if (result.victim_way !== want.victim_way ||
						result.streaming_seen !== want.streaming_seen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected victim=%0d stream=%0b, got victim=%0d stream=%0b",
							want.victim_way, want.streaming_seen,
							result.victim_way, result.streaming_seen);
				end
			end
		end
	end

	// Cycle counter that guards against a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	// Queues a run of updates with a fixed stride on one set.
	task automatic push_stride(int set, int stride, int n);
		logic [47:0] a;
		a = 48'({$urandom(), $urandom()});
		for (int i = 0; i < n; i++) begin
			pending_reqs.push_back(make_req(REQ_UPDATE, set, $urandom_range(0, 15),
				48'({$urandom(), $urandom()}), a, 1'($urandom_range(0, 1))));
			a = a + stride;
		end
	endtask

	task automatic wait_drain();
		while (pending_reqs.size() != 0 || start)
			@(negedge clk);
		while (expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int n;
		int hot_set;
		mismatches = 0;
		cycles     = 0;
		drain_hold = 1'b0;
		no_idle    = 1'b0;
		start      = 1'b0;
		req        = '0;
		arst_n     = 1'b0;
		clear_shadow();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: fresh set queries, hits, fills, extremes, streaming.
		pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, '0, '0, 0));
		pending_reqs.push_back(make_req(REQ_QUERY, 2047, 15, '1, '1, 1));
		pending_reqs.push_back(make_req(REQ_UPDATE, 5, 0, '0, '0, 1));
		pending_reqs.push_back(make_req(REQ_UPDATE, 5, 15, '1, '1, 1));
		pending_reqs.push_back(make_req(REQ_QUERY, 5, 0, '0, '0, 0));
		for (int w = 0; w < 16; w++)
			pending_reqs.push_back(make_req(REQ_UPDATE, 9, w, 48'h40, 48'h100 * w, 1));
		// All ways hit, so both scans fail and way 0 is answered after two agings.
		pending_reqs.push_back(make_req(REQ_QUERY, 9, 0, '0, '0, 0));
		pending_reqs.push_back(make_req(REQ_UPDATE, 9, 3, 48'h40, 48'h2000, 0));
		pending_reqs.push_back(make_req(REQ_UPDATE, 2047, 7, 48'hFFFF_0000_1234, '1, 0));
		push_stride(12, 64, 6);

		// Random part: mostly traffic focused on a few sets with strides,
		// hits on random ways and victim queries, plus plain noise.
		n = 0;
		while (n < 1100) begin
			if (n == 300) begin
				no_idle = 1'b1;
			end else if (n == 450) begin
				no_idle = 1'b0;
				wait_drain();
				drain_hold = 1'b1;
				repeat (8) @(negedge clk);
				drain_hold = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: begin
					pending_reqs.push_back(rand_req());
					n++;
				end
				1: begin
					push_stride($urandom_range(0, 7), $urandom_range(0, 3) * 64, 5);
					n += 5;
				end
				default: begin
					hot_set = $urandom_range(0, 7);
					for (int k = 0; k < 4; k++) begin
						pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), hot_set,
							$urandom_range(0, 15), {36'h0, 12'($urandom_range(0, 15))},
							48'({$urandom(), $urandom()}), $urandom_range(0, 3) != 0));
					end
					n += 4;
				end
			endcase
			while (pending_reqs.size() > 32)
				@(negedge clk);
		end
		wait_drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
